@@ rtl/core/msq_pkg.sv @@
// Shared types, segment lengths and the symbol code table of the Morse key sequencer.
`default_nettype none

package msq_pkg;

    // Segment lengths in dot units
    localparam logic [2:0] U_DOT    = 3'd1;
    localparam logic [2:0] U_DASH   = 3'd3;
    localparam logic [2:0] U_SEP    = 3'd1;
    localparam logic [2:0] U_LETTER = 3'd3;
    localparam logic [2:0] U_WORD   = 3'd7;

    localparam logic [7:0] CH_SPACE = 8'h20;

    // Longest code has eight elements
    localparam int MaxElems = 8;
    localparam int CntW     = $clog2(MaxElems + 1);

    // Gap that opens a character
    typedef enum logic [1:0] {
        GAP_NONE,
        GAP_LETTER,
        GAP_WORD
    } t_gap;

    // Code word: element count, elements MSB first, 1 = dash, 0 = dot
    typedef struct packed {
        logic [CntW-1:0]     len;
        logic [MaxElems-1:0] pat;
    } t_code;

    // Work handed to the segment emitter
    typedef struct packed {
        t_gap  gap;
        t_code code;
    } t_job;

    // Symbol table lookup; for the period the first table entry (.-.-.-) wins
    function automatic t_code f_lookup(input logic [7:0] ch);
        t_code c;
        c = '{len: '0, pat: '0};
        unique case (ch)
            8'h61: c = '{len: CntW'(2), pat: 8'b01000000};  // a
            8'h62: c = '{len: CntW'(4), pat: 8'b10000000};  // b
            8'h63: c = '{len: CntW'(4), pat: 8'b10100000};  // c
            8'h64: c = '{len: CntW'(3), pat: 8'b10000000};  // d
            8'h65: c = '{len: CntW'(1), pat: 8'b00000000};  // e
            8'h66: c = '{len: CntW'(4), pat: 8'b00100000};  // f
            8'h67: c = '{len: CntW'(3), pat: 8'b11000000};  // g
            8'h68: c = '{len: CntW'(4), pat: 8'b00000000};  // h
            8'h69: c = '{len: CntW'(2), pat: 8'b00000000};  // i
            8'h6A: c = '{len: CntW'(4), pat: 8'b01110000};  // j
            8'h6B: c = '{len: CntW'(3), pat: 8'b10100000};  // k
            8'h6C: c = '{len: CntW'(4), pat: 8'b01000000};  // l
            8'h6D: c = '{len: CntW'(2), pat: 8'b11000000};  // m
            8'h6E: c = '{len: CntW'(2), pat: 8'b10000000};  // n
            8'h6F: c = '{len: CntW'(3), pat: 8'b11100000};  // o
            8'h70: c = '{len: CntW'(4), pat: 8'b01100000};  // p
            8'h71: c = '{len: CntW'(4), pat: 8'b11010000};  // q
            8'h72: c = '{len: CntW'(3), pat: 8'b01000000};  // r
            8'h73: c = '{len: CntW'(3), pat: 8'b00000000};  // s
            8'h74: c = '{len: CntW'(1), pat: 8'b10000000};  // t
            8'h75: c = '{len: CntW'(3), pat: 8'b00100000};  // u
            8'h76: c = '{len: CntW'(4), pat: 8'b00010000};  // v
            8'h77: c = '{len: CntW'(3), pat: 8'b01100000};  // w
            8'h78: c = '{len: CntW'(4), pat: 8'b10010000};  // x
            8'h79: c = '{len: CntW'(4), pat: 8'b10110000};  // y
            8'h7A: c = '{len: CntW'(4), pat: 8'b11000000};  // z
            8'h31: c = '{len: CntW'(5), pat: 8'b01111000};  // 1
            8'h32: c = '{len: CntW'(5), pat: 8'b00111000};  // 2
            8'h33: c = '{len: CntW'(5), pat: 8'b00011000};  // 3
            8'h34: c = '{len: CntW'(5), pat: 8'b00001000};  // 4
            8'h35: c = '{len: CntW'(5), pat: 8'b00000000};  // 5
            8'h36: c = '{len: CntW'(5), pat: 8'b10000000};  // 6
            8'h37: c = '{len: CntW'(5), pat: 8'b11000000};  // 7
            8'h38: c = '{len: CntW'(5), pat: 8'b11100000};  // 8
            8'h39: c = '{len: CntW'(5), pat: 8'b11110000};  // 9
            8'h30: c = '{len: CntW'(5), pat: 8'b11111000};  // 0
            8'h2E: c = '{len: CntW'(6), pat: 8'b01010100};  // period
            8'h2C: c = '{len: CntW'(6), pat: 8'b11001100};  // comma
            8'h3F: c = '{len: CntW'(6), pat: 8'b00110000};  // question mark
            8'h2D: c = '{len: CntW'(6), pat: 8'b10000100};  // hyphen
            8'h3D: c = '{len: CntW'(5), pat: 8'b10001000};  // equals
            8'h3A: c = '{len: CntW'(6), pat: 8'b11100000};  // colon
            8'h3B: c = '{len: CntW'(6), pat: 8'b10101000};  // semicolon
            8'h28: c = '{len: CntW'(5), pat: 8'b10110000};  // open paren
            8'h29: c = '{len: CntW'(6), pat: 8'b10110100};  // close paren
            8'h2F: c = '{len: CntW'(5), pat: 8'b10010000};  // slash
            8'h22: c = '{len: CntW'(6), pat: 8'b01001000};  // double quote
            8'h24: c = '{len: CntW'(7), pat: 8'b00010010};  // dollar
            8'h27: c = '{len: CntW'(6), pat: 8'b01111000};  // apostrophe
            8'h0A: c = '{len: CntW'(6), pat: 8'b01010000};  // newline
            8'h5F: c = '{len: CntW'(6), pat: 8'b00110100};  // underscore
            8'h2B: c = '{len: CntW'(5), pat: 8'b01010000};  // plus
            8'h21: c = '{len: CntW'(6), pat: 8'b00010100};  // exclamation
            8'h18: c = '{len: CntW'(8), pat: 8'b00000000};  // cancel, eight dots
            default: c = '{len: '0, pat: '0};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/msq_emitter.sv @@
// Segment emitter: shifts a code word out one element per segment into an output register.
`default_nettype none

module msq_emitter
    import msq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_job       i_job,
    output logic            o_busy,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_key_on,
    output logic [2:0]      o_units,
    output logic            o_last_segment
);

    t_gap                r_gap, n_gap;
    logic [MaxElems-1:0] r_pat, n_pat;
    logic [CntW-1:0]     r_cnt, n_cnt;
    logic                r_sep, n_sep;
    logic                r_valid, n_valid;
    logic                r_key, n_key;
    logic [2:0]          r_units, n_units;
    logic                r_last, n_last;
    logic                slot_free;

    assign o_busy    = (r_gap != GAP_NONE) || (r_cnt != '0);
    assign slot_free = !r_valid || !i_stall;

    // Next segment selection: gap first, then separator / element alternately
    always_comb begin
        n_gap   = r_gap;
        n_pat   = r_pat;
        n_cnt   = r_cnt;
        n_sep   = r_sep;
        n_valid = r_valid && i_stall;
        n_key   = r_key;
        n_units = r_units;
        n_last  = r_last;
        if (i_load) begin
            n_gap = i_job.gap;
            n_pat = i_job.code.pat;
            n_cnt = i_job.code.len;
            n_sep = 1'b0;
        end else if (o_busy && slot_free) begin
            n_valid = 1'b1;
            if (r_gap != GAP_NONE) begin
                n_key   = 1'b0;
                n_units = (r_gap == GAP_WORD) ? U_WORD : U_LETTER;
                n_last  = (r_cnt == '0);
                n_gap   = GAP_NONE;
            end else if (r_sep) begin
                n_key   = 1'b0;
                n_units = U_SEP;
                n_last  = 1'b0;
                n_sep   = 1'b0;
            end else begin
                n_key   = 1'b1;
                n_units = r_pat[MaxElems-1] ? U_DASH : U_DOT;
                n_last  = (r_cnt == CntW'(1));
                n_pat   = {r_pat[MaxElems-2:0], 1'b0};
                n_cnt   = r_cnt - CntW'(1);
                n_sep   = (r_cnt > CntW'(1));
            end
        end
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= GAP_NONE;
            r_cnt   <= '0;
            r_sep   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_gap   <= n_gap;
            r_cnt   <= n_cnt;
            r_sep   <= n_sep;
            r_valid <= n_valid;
        end
        r_pat   <= n_pat;
        r_key   <= n_key;
        r_units <= n_units;
        r_last  <= n_last;
    end

    assign o_valid        = r_valid;
    assign o_key_on       = r_key;
    assign o_units        = r_units;
    assign o_last_segment = r_last;

endmodule

`default_nettype wire

@@ rtl/core/morse_key_sequencer_top.sv @@
// Morse key sequencer top level: input handshake, word-start tracking and code lookup.
//
// Input channel: one ASCII character per transaction (i_valid / o_stall).
// Output channel: one key segment per transaction (o_valid / i_stall), giving
// the key level, its length in dot units and a flag on the last segment that
// a character causes. A space gives a 7-unit off segment; other characters
// give a 3-unit letter gap (not at a word start) and then their code elements
// separated by 1-unit off segments. Unknown characters give at most the gap.
// On a transaction the job is loaded into the emitter state registers, and
// the first segment is then registered into the output register. The emitter
// produces one segment per cycle while the receiver does not stall, and a
// character gives at most sixteen segments; the next character is taken once
// the last segment has entered the output register. The single output
// register and the per-segment shift of the code word set that pace.
// Reset clears the emitter state and the output valid flag and marks a word start.
// While the receiver stalls, the shown segment holds and no new segment is
// made; o_stall stays high until the character's last segment is registered.
`default_nettype none

module morse_key_sequencer_top
    import msq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_character,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_key_on,
    output logic [2:0]      o_units,
    output logic            o_last_segment
);

    logic r_at_word_start;
    logic n_at_word_start;
    logic busy;
    logic accept;
    t_job job;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    // Build the job for the emitter
    always_comb begin
        n_at_word_start = r_at_word_start;
        if (i_character == CH_SPACE) begin
            job.gap  = GAP_WORD;
            job.code = '{len: '0, pat: '0};
        end else begin
            job.gap  = r_at_word_start ? GAP_NONE : GAP_LETTER;
            job.code = f_lookup(i_character);
        end
        if (accept) begin
            n_at_word_start = (i_character == CH_SPACE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_word_start <= 1'b1;
        end else begin
            r_at_word_start <= n_at_word_start;
        end
    end

    msq_emitter u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept),
        .i_job          (job),
        .o_busy         (busy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_key_on       (o_key_on),
        .o_units        (o_units),
        .o_last_segment (o_last_segment)
    );

endmodule

`default_nettype wire

@@ rtl/core/msq_checker.sv @@
// Port-level checker for the Morse key sequencer and its bind to the top level.
`default_nettype none

module msq_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_key_on,
    input wire logic [2:0] o_units,
    input wire logic       o_last_segment
);

    // Stalled segment holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_key_on) && $stable(o_units)
            && $stable(o_last_segment))
        else $error("stalled segment changed");

    // Key-on segments are dots or dashes
    a_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_key_on |-> o_units == 3'd1 || o_units == 3'd3)
        else $error("bad element length");

    // Word gap is off and ends the character
    a_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_units == 3'd7 |-> !o_key_on && o_last_segment)
        else $error("bad word gap");

    // An element separator is never the last segment
    a_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_key_on && o_units == 3'd1 |-> !o_last_segment)
        else $error("separator flagged last");

    // New characters are refused while segments of the current one remain
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_segment && !i_stall && o_units != 3'd1 |-> o_stall)
        else $error("input taken mid character");

endmodule

bind morse_key_sequencer_top msq_checker u_msq_checker (.*);

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the Morse key sequencer with a segment scoreboard.
`timescale 1ns / 1ps

module tb;
    import msq_pkg::*;

    localparam int DirectedMax = 25;
    localparam int PhaseItems  = 42;
    localparam int HoldAt      = 130;
    localparam int HoldCycles  = 250;
    localparam int IdleLimit   = 3000;
    localparam int TailCycles  = 24;
    localparam int ReportMax   = 10;

    // One key segment as seen on the output channel
    typedef struct packed {
        logic       key_on;
        logic [2:0] units;
        logic       last_segment;
    } t_seg;

    // Dot/dash pattern of a symbol; the first table entry for the period wins
    function automatic string morse_pattern(input logic [7:0] ch);
        case (ch)
            "a": return ".-";      "b": return "-...";    "c": return "-.-.";
            "d": return "-..";     "e": return ".";       "f": return "..-.";
            "g": return "--.";     "h": return "....";    "i": return "..";
            "j": return ".---";    "k": return "-.-";     "l": return ".-..";
            "m": return "--";      "n": return "-.";      "o": return "---";
            "p": return ".--.";    "q": return "--.-";    "r": return ".-.";
            "s": return "...";     "t": return "-";       "u": return "..-";
            "v": return "...-";    "w": return ".--";     "x": return "-..-";
            "y": return "-.--";    "z": return "--..";
            "1": return ".----";   "2": return "..---";   "3": return "...--";
            "4": return "....-";   "5": return ".....";   "6": return "-....";
            "7": return "--...";   "8": return "---..";   "9": return "----.";
            "0": return "-----";
            ".": return ".-.-.-";  ",": return "--..--";  "?": return "..--..";
            "-": return "-....-";  "=": return "-...-";   ":": return "---...";
            ";": return "-.-.-.";  "(": return "-.--.";   ")": return "-.--.-";
            "/": return "-..-.";   "\"": return ".-..-."; "$": return "...-..-";
            "'": return ".----.";  8'h0A: return ".-.-..";
            "_": return "..--.-";  "+": return ".-.-.";   "!": return "...-.-";
            8'h18: return "........";
            default: return "";
        endcase
    endfunction

    // Keeps the word-start flag and the queue of segments still to come
    class segment_scoreboard;
        t_seg segs_due[$];
        bit   word_start;
        int   failures;

        function new();
            word_start = 1'b1;
            failures   = 0;
        endfunction

        // Predict the segments for one accepted character
        function void note_char(input logic [7:0] ch);
            t_seg  segs[$];
            t_seg  s;
            string pat;
            pat = "";
            if (ch == CH_SPACE) begin
                segs.push_back('{1'b0, U_WORD, 1'b0});
                word_start = 1'b1;
            end else begin
                if (!word_start)
                    segs.push_back('{1'b0, U_LETTER, 1'b0});
                word_start = 1'b0;
                pat = morse_pattern(ch);
                for (int k = 0; k < pat.len(); k++) begin
                    if (k > 0)
                        segs.push_back('{1'b0, U_SEP, 1'b0});
                    segs.push_back('{1'b1, (pat[k] == "-") ? U_DASH : U_DOT, 1'b0});
                end
            end
            if (segs.size() > 0) begin
                s = segs.pop_back();
                s.last_segment = 1'b1;
                segs.push_back(s);
            end
            foreach (segs[i])
                segs_due.push_back(segs[i]);
        endfunction

        // Compare one output transaction with the oldest prediction
        function void check_segment(input t_seg got);
            t_seg want;
            if (segs_due.size() == 0) begin
                failures++;
                if (failures <= ReportMax)
                    $display("unexpected segment: key_on=%0b units=%0d last=%0b",
                             got.key_on, got.units, got.last_segment);
                return;
            end
            want = segs_due.pop_front();
            if (got != want) begin
                failures++;
                if (failures <= ReportMax)
                    $display({"segment mismatch: exp key_on=%0b units=%0d last=%0b,",
                              " got key_on=%0b units=%0d last=%0b"},
                             want.key_on, want.units, want.last_segment,
                             got.key_on, got.units, got.last_segment);
            end
        endfunction

        function int pending();
            return segs_due.size();
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_character = 8'h00;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_key_on;
    logic [2:0] o_units;
    logic       o_last_segment;

    int tx_idle_pct    = 8;
    int rx_idle_pct    = 72;
    int chars_accepted = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int quiet_cycles   = 0;

    string coded_syms = "abcdefghijklmnopqrstuvwxyz0123456789.,?-=:;()/\"$'\n_+!\030";

    segment_scoreboard sb = new();

    morse_key_sequencer_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_character    (i_character),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_key_on       (o_key_on),
        .o_units        (o_units),
        .o_last_segment (o_last_segment)
    );

    always #5 i_clk = ~i_clk;

    // Monitor both channels at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_char(i_character);
                chars_accepted <= chars_accepted + 1;
            end
            if (o_valid && !i_stall)
                sb.check_segment('{o_key_on, o_units, o_last_segment});
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && chars_accepted >= HoldAt) begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Watchdog: no transaction on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IdleLimit) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one character, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] ch);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= ch;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Mostly table symbols and spaces, some upper case and arbitrary bytes
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return coded_syms[$urandom_range(0, coded_syms.len() - 1)];
        else if (r < 80)
            return CH_SPACE;
        else if (r < 88)
            return 8'($urandom_range(65, 90));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    logic [7:0] directed_chars [DirectedMax] = '{
        8'h00, "e", "t", "A", 8'h00, 8'h18, ".", " ", " ", "a", 8'hFF, "$",
        8'h0A, "_", "0", "5", ",", "?", " ", "!", "+", 8'h7F, "z", "Z", 8'h80
    };

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles rarely, receiver often
        tx_idle_pct = 8;
        rx_idle_pct = 72;
        foreach (directed_chars[i])
            send_char(directed_chars[i]);
        for (int n = 0; n < PhaseItems; n++)
            send_char(pick_char());

        // Sender idles often, receiver rarely
        tx_idle_pct = 72;
        rx_idle_pct = 8;
        for (int n = 0; n < PhaseItems; n++)
            send_char(pick_char());

        // No idling; the receiver hold-off lands in this stretch
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int n = 0; n < PhaseItems; n++)
            send_char(pick_char());
        i_valid <= 1'b0;

        // Drain, then watch for stray segments
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
